@@ sv/b64u_pkg.sv @@
// Shared beat types and constants for the base64url stream decoder.
`timescale 1ns / 1ps
`default_nettype none
package b64u_pkg;

  // One input beat: a raw character and the end-of-token flag.
  typedef struct packed {
    logic [7:0] char_in;
    logic       token_end;
  } in_beat_t;

  // One result beat: a decoded byte, its qualifier and the end-of-token flag.
  typedef struct packed {
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       done_res;
  } out_beat_t;

  // Character classification passed from the map to the decode step.
  typedef struct packed {
    logic       is_sextet;
    logic       is_pad;
    logic [5:0] value;
  } sextet_t;

  localparam logic [7:0]  CHAR_PAD     = 8'h3D;  // '='
  localparam logic [7:0]  CHAR_DASH    = 8'h2D;  // '-'
  localparam logic [7:0]  CHAR_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0]  CHAR_UNDER   = 8'h5F;  // '_'
  localparam logic [7:0]  CHAR_SLASH   = 8'h2F;  // '/'
  localparam logic [3:0]  OFFSET_RESET = 4'sb1000;  // minus eight

endpackage
`default_nettype wire

@@ sv/b64u_sextet_map.sv @@
// Maps one character to its 6-bit base64url value and flags padding.
`timescale 1ns / 1ps
`default_nettype none
module b64u_sextet_map (
  input  wire logic [7:0]       char_in,
  output b64u_pkg::sextet_t     sextet
);

  // Range compares select the letter and digit groups; symbols are matched exactly.
  always_comb begin
    sextet = '0;
    if (char_in >= 8'h41 && char_in <= 8'h5A) begin
      sextet.is_sextet = 1'b1;
      sextet.value     = 6'(char_in - 8'h41);
    end else if (char_in >= 8'h61 && char_in <= 8'h7A) begin
      sextet.is_sextet = 1'b1;
      sextet.value     = 6'(char_in - 8'h61 + 8'd26);
    end else if (char_in >= 8'h30 && char_in <= 8'h39) begin
      sextet.is_sextet = 1'b1;
      sextet.value     = 6'(char_in - 8'h30 + 8'd52);
    end else if (char_in == b64u_pkg::CHAR_DASH || char_in == b64u_pkg::CHAR_PLUS) begin
      sextet.is_sextet = 1'b1;
      sextet.value     = 6'd62;
    end else if (char_in == b64u_pkg::CHAR_UNDER || char_in == b64u_pkg::CHAR_SLASH) begin
      sextet.is_sextet = 1'b1;
      sextet.value     = 6'd63;
    end else if (char_in == b64u_pkg::CHAR_PAD) begin
      sextet.is_pad = 1'b1;
    end
  end

endmodule
`default_nettype wire

@@ sv/b64u_decode_step.sv @@
// Token state (accumulator, bit offset, stop flag) and the per-character decode.
`timescale 1ns / 1ps
`default_nettype none
module b64u_decode_step (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step_en,
  input  wire b64u_pkg::in_beat_t  beat,
  output b64u_pkg::out_beat_t      result
);

  logic [11:0]       acc_r,     acc_nxt;
  logic signed [3:0] offset_r,  offset_nxt;
  logic              stopped_r, stopped_nxt;

  b64u_pkg::sextet_t sextet;
  logic [11:0]       acc_shifted;
  logic signed [4:0] offset_sum;
  logic signed [4:0] offset_after;
  logic [7:0]        acc_aligned;

  b64u_sextet_map u_map (
    .char_in (beat.char_in),
    .sextet  (sextet)
  );

  // Shift the new sextet in and work out whether a whole byte is now available.
  always_comb begin
    acc_shifted  = {acc_r[5:0], sextet.value};
    offset_sum   = 5'(offset_r) + 5'sd6;
    offset_after = offset_sum;
    acc_aligned  = 8'(acc_shifted >> offset_sum[3:0]);

    acc_nxt            = acc_r;
    offset_nxt         = offset_r;
    stopped_nxt        = stopped_r;
    result.byte_out    = '0;
    result.byte_valid  = 1'b0;
    result.done_res    = beat.token_end;

    if (!stopped_r) begin
      if (sextet.is_pad) begin
        stopped_nxt = 1'b1;
      end else if (sextet.is_sextet) begin
        acc_nxt = acc_shifted;
        if (offset_sum >= 0) begin
          result.byte_out   = acc_aligned;
          result.byte_valid = 1'b1;
          offset_after      = offset_sum - 5'sd8;
        end
        // Keep the offset inside its 4-bit signed range.
        if (offset_after < -5'sd8 || offset_after > 5'sd7) begin
          offset_nxt = b64u_pkg::OFFSET_RESET;
        end else begin
          offset_nxt = offset_after[3:0];
        end
      end
    end

    // The last character of a token returns the state to its reset values.
    if (beat.token_end) begin
      acc_nxt     = '0;
      offset_nxt  = b64u_pkg::OFFSET_RESET;
      stopped_nxt = 1'b0;
    end
  end

  // State advances only when a character is taken by the result stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      offset_r  <= b64u_pkg::OFFSET_RESET;
      stopped_r <= 1'b0;
    end else if (step_en) begin
      acc_r     <= acc_nxt;
      offset_r  <= offset_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule
`default_nettype wire

@@ sv/base64url_stream_decoder_core.sv @@
// Top level of the base64url stream decoder: input stage, decode step, result stage.
//
// Usage: each input beat carries one raw character and a token_end flag.
// Every input beat gives exactly one result beat, in order: the decoded byte
// with byte_valid set when that character completed a byte, and done_res set
// on the beat for the token's last character. Characters outside the alphabet
// produce a result with byte_valid low; an '=' halts decoding until token end.
// An accepted beat passes from the input register to the result register,
// whose valid bit drives out_valid; there is one input register and one
// result register.
// Throughput: one character per cycle while the receiver does not stall; the
// combinational decode between the two registers also updates the token
// state. When the receiver stalls, the result register holds its beat and the
// input register can still take one more character before in_stall rises.
// Reset (synchronous, rst_n low) empties both registers and returns the
// accumulator, bit offset and stop flag to their token-start values.
`timescale 1ns / 1ps
`default_nettype none
module base64url_stream_decoder_core (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire b64u_pkg::in_beat_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output b64u_pkg::out_beat_t       out_data
);

  logic                s1_valid_r, s1_valid_nxt;
  b64u_pkg::in_beat_t  s1_beat_r;
  logic                out_valid_r, out_valid_nxt;
  b64u_pkg::out_beat_t out_beat_r;
  b64u_pkg::out_beat_t step_result;
  logic                in_take;
  logic                s1_advance;

  // Handshake: the input stage moves on when the result register is free or draining.
  assign s1_advance = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall   = s1_valid_r && !s1_advance;
  assign in_take    = in_valid && !in_stall;

  b64u_decode_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_advance),
    .beat    (s1_beat_r),
    .result  (step_result)
  );

  // Valid bits of both stages.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_advance) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load only on a transfer into their stage.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_beat_r <= in_data;
    end
    if (s1_advance) begin
      out_beat_r <= step_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule
`default_nettype wire

@@ tb/base64url_stream_decoder_core_test.sv @@
// Self-checking testbench for the base64url stream decoder core.
`timescale 1ns / 1ps
`default_nettype none
module base64url_stream_decoder_core_test;

  localparam int HOLD_CYCLES  = 200;
  localparam int IDLE_LIMIT   = 2000;
  localparam int TARGET_ITEMS = 1050;
  localparam int REPORT_LIMIT = 10;

  // Tracks the token state and the queue of result beats still owed by the block.
  class decode_scoreboard;
    b64u_pkg::out_beat_t expected_q[$];
    logic [11:0]         acc;
    int                  offset;
    bit                  halted;
    int                  errors;

    function new();
      clear_token();
      errors = 0;
    endfunction

    function void clear_token();
      acc    = '0;
      offset = -8;
      halted = 1'b0;
    endfunction

    // Six-bit value of a character, or -1 when it is outside the alphabet.
    function int sextet(logic [7:0] c);
      if (c >= "A" && c <= "Z") return int'(c) - int'("A");
      if (c >= "a" && c <= "z") return int'(c) - int'("a") + 26;
      if (c >= "0" && c <= "9") return int'(c) - int'("0") + 52;
      if (c == b64u_pkg::CHAR_DASH || c == b64u_pkg::CHAR_PLUS) return 62;
      if (c == b64u_pkg::CHAR_UNDER || c == b64u_pkg::CHAR_SLASH) return 63;
      return -1;
    endfunction

    // Decode one accepted character and queue the result beat it must produce.
    function void note_char(b64u_pkg::in_beat_t beat);
      b64u_pkg::out_beat_t exp_beat;
      int                  v;
      exp_beat = '0;
      exp_beat.done_res = beat.token_end;
      if (!halted) begin
        if (beat.char_in == b64u_pkg::CHAR_PAD) begin
          halted = 1'b1;
        end else begin
          v = sextet(beat.char_in);
          if (v >= 0) begin
            acc = {acc[5:0], 6'(v)};
            offset += 6;
            if (offset >= 0) begin
              exp_beat.byte_out   = 8'(acc >> offset);
              exp_beat.byte_valid = 1'b1;
              offset -= 8;
            end
            if (offset < -8 || offset > 7) offset = -8;
          end
        end
      end
      expected_q.push_back(exp_beat);
      if (beat.token_end) clear_token();
    endfunction

    // Compare one accepted result beat with the oldest expectation.
    function void check_result(b64u_pkg::out_beat_t got);
      b64u_pkg::out_beat_t exp_beat;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("unexpected result: byte=%02h valid=%0d done=%0d",
                   got.byte_out, got.byte_valid, got.done_res);
        return;
      end
      exp_beat = expected_q.pop_front();
      if (got.byte_out !== exp_beat.byte_out || got.byte_valid !== exp_beat.byte_valid ||
          got.done_res !== exp_beat.done_res) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("mismatch: expected byte=%02h valid=%0d done=%0d, %s",
                   exp_beat.byte_out, exp_beat.byte_valid, exp_beat.done_res,
                   $sformatf("got byte=%02h valid=%0d done=%0d",
                             got.byte_out, got.byte_valid, got.done_res));
      end
    endfunction

    function int failures();
      return errors + expected_q.size();
    endfunction
  endclass

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_stall;
  b64u_pkg::in_beat_t  in_data   = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  b64u_pkg::out_beat_t out_data;

  decode_scoreboard sb = new();
  string url_alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
  int    items_sent = 0;
  bit    hold_req   = 1'b0;
  bit    hold_done  = 1'b0;
  int    idle_cycles = 0;

  base64url_stream_decoder_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sample both channels at the edge where a beat is accepted.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_char(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat accepted for %0d cycles", IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int run_len();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 12);
    return $urandom_range(40, 150);
  endfunction

  // Offer one beat, wait for it to be taken, then idle for a random gap unless no_gap is set.
  task automatic send_beat(input logic [7:0] ch, input logic last, input bit no_gap);
    int gap;
    in_data  <= '{char_in: ch, token_end: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    items_sent++;
    gap = no_gap ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_token(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1, 1'b0);
  endtask

  // Mostly well-formed tokens with random content; some noise and padding.
  task automatic random_token();
    int         len;
    int         r;
    bit         no_gap;
    logic [7:0] ch;
    len    = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 64) : $urandom_range(1, 16);
    no_gap = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (i >= len - 2 && r < 20) ch = b64u_pkg::CHAR_PAD;
      else if (r < 86) ch = url_alphabet[$urandom_range(0, 63)];
      else if (r < 88) ch = (r == 86) ? b64u_pkg::CHAR_PLUS : b64u_pkg::CHAR_SLASH;
      else if (r < 97) ch = 8'($urandom_range(0, 255));
      else ch = b64u_pkg::CHAR_PAD;
      send_beat(ch, i == len - 1, no_gap);
    end
  endtask

  // The receiver holds off for a long stretch while back-to-back beats keep coming.
  task automatic pressure_burst();
    hold_req = 1'b1;
    for (int i = 0; i < 48; i++) send_beat(url_alphabet[$urandom_range(0, 63)], i == 47, 1'b1);
  endtask

  // Receiver: alternating stall and run segments, plus one long hold on request.
  initial begin
    int seg_left;
    bit stalled;
    seg_left = 0;
    stalled  = 1'b0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        stalled  = 1'b0;
        seg_left = $urandom_range(20, 60);
        out_stall <= 1'b0;
      end else begin
        if (seg_left == 0) begin
          stalled  = !stalled;
          seg_left = stalled ? stall_len() : run_len();
        end
        seg_left--;
        out_stall <= stalled;
      end
    end
  end

  // Main sequence: reset, directed tokens, random tokens, drain and verdict.
  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Range ends of every alphabet group and both symbol spellings.
    send_token("AZaz09-+_/");
    // Characters just outside each range; only one sextet, so no byte.
    send_token("Q@[`{:");
    // NUL and high bytes are skipped; a token of only skipped characters.
    send_beat(8'h00, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat(8'h80, 1'b1, 1'b0);
    // Padding mid-token halts decoding until the end flag.
    send_token("T=x");
    // Padding carrying the end flag.
    send_token("=");

    while (items_sent < TARGET_ITEMS) begin
      if (!hold_req && items_sent >= TARGET_ITEMS / 2) pressure_burst();
      random_token();
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
`default_nettype wire
